>>> hdl/pess_pkg.sv
// Shared types and field widths for the per-set even spread sampler.
package pess_pkg;

  // Fixed field widths
  localparam int SET_IDX_W = 4;
  localparam int CAT_W     = 5;
  localparam int TAG_W     = 32;
  localparam int SEL_SET_W = 4;
  localparam int OUT_W     = ((TAG_W + SEL_SET_W + 7) / 8) * 8;

  // Beat kinds carried on tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_RECORD = 1'b1;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // input beat taken this cycle
    logic rd;        // table read cycle
    logic mul_step;  // one half-step of the phase product
    logic wr_load;   // write loaded parameters and phase
    logic wr_rec;    // write updated phase after a record
    logic emit;      // load the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_op;     // incoming beat is a record
    logic ld_ok;     // load set index in range
    logic ld_mul;    // load needs the phase product
    logic rec_ok;    // record category in range
    logic hit;       // record is selected
    logic mul_done;  // last half-step of the product
    logic out_busy;  // output register full and stalled
  } sts_t;

endpackage

>>> hdl/per_set_even_spread_sampler.sv
// Record beat: accepted, table read, phase update; a selected record loads the output register.
// In-set record beats pass through the read and update states before the next beat is taken;
// update holds while a selected record meets a stalled output. Records outside any set and
// out-of-range loads are dropped in idle. Loads that need the phase product step through the two
// half-steps per prior_count bit of the shared compare-subtract unit, then write; other in-range
// loads go straight to the write. Reset is synchronous: it clears the controller, the output
// valid and the per-set valid bits, so every set reads as zero counts until it is loaded.
module per_set_even_spread_sampler #(
  parameter int NUM_SETS    = 16,
  parameter int COUNT_WIDTH = 40
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // set_index, wanted_count, total_count, prior_count, category, row_tag, zero pad
  input  logic [((pess_pkg::SET_IDX_W + 3*COUNT_WIDTH + pess_pkg::CAT_W
                  + pess_pkg::TAG_W + 7) / 8) * 8 - 1:0] s_tdata,
  // op
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // selected_tag, selected_set, zero pad
  output logic [pess_pkg::OUT_W-1:0] m_tdata
);

  pess_pkg::cmd_t cmd;
  pess_pkg::sts_t sts;

  pess_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pess_datapath #(
    .NUM_SETS    (NUM_SETS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .cmd      (cmd),
    .sts      (sts),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // A result is never loaded over one that is still stalled
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !sts.out_busy)
    else $error("result loaded into a stalled output register");

  // No table write while a new beat can be taken
  a_wr_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_load || cmd.wr_rec) |-> !s_tready)
    else $error("table write while accepting input");

  // A loaded result is presented on the next cycle
  a_emit_show: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("emitted result not presented");

  // Only record updates emit results
  a_emit_rec: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> cmd.wr_rec)
    else $error("result emitted outside a record update");

endmodule

>>> hdl/pess_ram.sv
// Generic single write port RAM with registered read.
module pess_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/pess_ctrl.sv
// Controller state machine for the per-set even spread sampler.
module pess_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  pess_pkg::sts_t sts,
  output pess_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_UPDATE = 3'd2;
  localparam logic [2:0] ST_MUL    = 3'd3;
  localparam logic [2:0] ST_WRITE  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          if (sts.in_op) begin
            if (sts.rec_ok) state_next = ST_READ;
          end else if (sts.ld_ok) begin
            state_next = sts.ld_mul ? ST_MUL : ST_WRITE;
          end
        end
      end
      ST_READ: begin
        cmd.rd     = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        // hold while a selected record has nowhere to go
        if (!(sts.hit && sts.out_busy)) begin
          cmd.wr_rec = 1'b1;
          cmd.emit   = sts.hit;
          state_next = ST_IDLE;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr_load = 1'b1;
        state_next  = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/pess_datapath.sv
// Datapath: field capture, set table, phase update and modular product.
module pess_datapath #(
  parameter int NUM_SETS    = 16,
  parameter int COUNT_WIDTH = 40
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [((pess_pkg::SET_IDX_W + 3*COUNT_WIDTH + pess_pkg::CAT_W
                  + pess_pkg::TAG_W + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                        s_tuser,
  input  pess_pkg::cmd_t              cmd,
  output pess_pkg::sts_t              sts,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [pess_pkg::OUT_W-1:0]  m_tdata
);

  localparam int CW      = COUNT_WIDTH;
  localparam int SET_W   = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int CNT_W   = $clog2(COUNT_WIDTH);
  localparam int OFF_NUM = pess_pkg::SET_IDX_W;
  localparam int OFF_DEN = OFF_NUM + CW;
  localparam int OFF_PRI = OFF_DEN + CW;
  localparam int OFF_CAT = OFF_PRI + CW;
  localparam int OFF_TAG = OFF_CAT + pess_pkg::CAT_W;
  localparam int ENT_W   = 3 * CW;

  // Input fields
  logic [pess_pkg::SET_IDX_W-1:0] in_set;
  logic [CW-1:0]                  in_num;
  logic [CW-1:0]                  in_den;
  logic [CW-1:0]                  in_pri;
  logic [pess_pkg::CAT_W-1:0]     in_cat;
  logic [pess_pkg::TAG_W-1:0]     in_tag;

  assign in_set = s_tdata[0 +: pess_pkg::SET_IDX_W];
  assign in_num = s_tdata[OFF_NUM +: CW];
  assign in_den = s_tdata[OFF_DEN +: CW];
  assign in_pri = s_tdata[OFF_PRI +: CW];
  assign in_cat = s_tdata[OFF_CAT +: pess_pkg::CAT_W];
  assign in_tag = s_tdata[OFF_TAG +: pess_pkg::TAG_W];

  // Captured item
  logic [SET_W-1:0]          idx_r;
  logic [pess_pkg::TAG_W-1:0] tag_r;
  logic [CW-1:0]             num_r;
  logic [CW-1:0]             den_r;
  logic [CW-1:0]             pri_r;
  logic [CW-1:0]             acc_r;
  logic [CNT_W-1:0]          bit_cnt;
  logic                      half_r;

  // Table storage and per-entry valid bits
  logic [ENT_W-1:0] rdata;
  logic [ENT_W-1:0] wdata;
  logic             we;
  logic             valid [NUM_SETS];
  logic             rd_valid;

  // Record update
  logic [CW-1:0] rd_num;
  logic [CW-1:0] rd_den;
  logic [CW-1:0] rd_ph;
  logic          sel_all;
  logic [CW:0]   sum;
  logic [CW:0]   diff;
  logic          over;
  logic [CW-1:0] new_ph;

  // Shared compare-subtract for the product
  logic [CW:0]   dbl;
  logic [CW:0]   addv;
  logic [CW:0]   operand;
  logic [CW:0]   red_diff;
  logic [CW-1:0] reduced;

  // Status towards the controller
  always_comb begin
    sts.in_op    = (s_tuser == pess_pkg::OP_RECORD);
    sts.ld_ok    = 32'(in_set) < 32'(NUM_SETS);
    sts.ld_mul   = (in_num != '0) && (in_num < in_den);
    sts.rec_ok   = (in_cat != '0) && (32'(in_cat) <= 32'(NUM_SETS));
    sts.hit      = sel_all || over;
    sts.mul_done = half_r && (bit_cnt == '0);
    sts.out_busy = m_tvalid && !m_tready;
  end

  // Entry fields, zero where never written
  assign rd_num  = rd_valid ? rdata[0 +: CW]      : '0;
  assign rd_den  = rd_valid ? rdata[CW +: CW]     : '0;
  assign rd_ph   = rd_valid ? rdata[2*CW +: CW]   : '0;
  assign sel_all = rd_num >= rd_den;
  assign sum     = {1'b0, rd_ph} + {1'b0, rd_num};
  assign over    = sum >= {1'b0, rd_den};
  assign diff    = sum - {1'b0, rd_den};
  assign new_ph  = sel_all ? rd_ph : (over ? diff[CW-1:0] : sum[CW-1:0]);

  // Product step: double on the first half, add numerator on the second if the prior bit is set
  assign dbl      = {acc_r, 1'b0};
  assign addv     = {1'b0, acc_r} + {1'b0, num_r};
  assign operand  = !half_r ? dbl : (pri_r[CW-1] ? addv : {1'b0, acc_r});
  assign red_diff = operand - {1'b0, den_r};
  assign reduced  = (operand >= {1'b0, den_r}) ? red_diff[CW-1:0] : operand[CW-1:0];

  // Capture and product iteration
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r   <= (s_tuser == pess_pkg::OP_RECORD) ? SET_W'(in_cat - pess_pkg::CAT_W'(1))
                                                  : SET_W'(in_set);
      tag_r   <= in_tag;
      num_r   <= in_num;
      den_r   <= in_den;
      pri_r   <= in_pri;
      acc_r   <= '0;
      bit_cnt <= CNT_W'(COUNT_WIDTH - 1);
      half_r  <= 1'b0;
    end else if (cmd.mul_step) begin
      acc_r  <= reduced;
      half_r <= !half_r;
      if (half_r) begin
        pri_r   <= {pri_r[CW-2:0], 1'b0};
        bit_cnt <= bit_cnt - CNT_W'(1);
      end
    end
  end

  // Table write
  assign we    = cmd.wr_load || cmd.wr_rec;
  assign wdata = cmd.wr_load ? {acc_r, den_r, num_r} : {new_ph, rd_den, rd_num};

  pess_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SETS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (idx_r),
    .wdata (wdata),
    .raddr (idx_r),
    .rdata (rdata)
  );

  // Valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SETS; i++) valid[i] <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (we) valid[idx_r] <= 1'b1;
      if (cmd.rd) rd_valid <= valid[idx_r];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= pess_pkg::OUT_W'({pess_pkg::SEL_SET_W'(idx_r), tag_r});
    end
  end

endmodule
